// ===== hw/rtl/quick_disk_ready_window_sequencer_core_assert.svh =====
// Assertion macros shared by the read-window sequencer RTL.
// Expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef QUICK_DISK_READY_WINDOW_SEQUENCER_CORE_ASSERT_SVH
`define QUICK_DISK_READY_WINDOW_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define QDRWS_ASSERT_IMP(label, cond, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error("qdrws: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define QDRWS_ASSERT_NXT(label, cond, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error("qdrws: next-cycle check failed");

`endif

// ===== hw/rtl/qdrws_pkg.sv =====
// Package for the read-window sequencer: widths, codes, reset values and helpers.
// No dependencies; imported by the input-channel interface and the top level.
`timescale 1ns / 1ps

package qdrws_pkg;

    localparam int TIME_WIDTH = 24;
    localparam int SUM_WIDTH  = TIME_WIDTH + 2;
    localparam int CFG_WIDTH  = 24;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_WIDTH = 4;

    localparam logic [CFG_WIDTH-1:0] RST_WINDOW_START = CFG_WIDTH'(0);
    localparam logic [CFG_WIDTH-1:0] RST_WINDOW_END   = CFG_WIDTH'(0);
    localparam logic [CFG_WIDTH-1:0] RST_READ_LEAD    = CFG_WIDTH'(10000);
    localparam logic [CFG_WIDTH-1:0] RST_READ_TRAIL   = CFG_WIDTH'(10000);

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_INDEX  = 2'd1,
        OP_RESUME = 2'd2,
        OP_CANCEL = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REG_WINDOW_START = 2'd0,
        REG_WINDOW_END   = 2'd1,
        REG_READ_LEAD    = 2'd2,
        REG_READ_TRAIL   = 2'd3
    } t_reg;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_LEAD  = 3'd1,
        PH_READ  = 3'd2,
        PH_READY = 3'd3,
        PH_TRAIL = 3'd4,
        PH_DONE  = 3'd5
    } t_phase;

    function automatic logic [TIME_WIDTH-1:0] sat_sub(input logic [TIME_WIDTH-1:0] a,
                                                      input logic [TIME_WIDTH-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

endpackage

// ===== hw/rtl/qdrws_if.sv =====
// Valid/ready channel interfaces for the read-window sequencer's input and result words.
// Depends on qdrws_pkg for field widths.
`timescale 1ns / 1ps

interface qdrws_in_if
    import qdrws_pkg::*;
    ;
    logic                  valid;
    logic                  ready;
    logic [1:0]            operation;
    logic                  motor_ready;
    logic                  read_active;
    logic                  write_active;
    logic                  paused;
    logic [CFG_WIDTH-1:0]  resume_position;

    modport source (output valid, operation, motor_ready, read_active, write_active,
                    paused, resume_position, input ready);
    modport sink   (input valid, operation, motor_ready, read_active, write_active,
                    paused, resume_position, output ready);
endinterface

interface qdrws_out_if;
    logic       valid;
    logic       ready;
    logic       read_data_enable;
    logic       ready_asserted;
    logic       stop_write;
    logic [2:0] phase;

    modport source (output valid, read_data_enable, ready_asserted, stop_write, phase,
                    input ready);
    modport sink   (input valid, read_data_enable, ready_asserted, stop_write, phase,
                    output ready);
endinterface

// ===== hw/rtl/quick_disk_ready_window_sequencer_core.sv =====
// Read-window sequencer core: input register, one pass of next-state logic, result register.
// Depends on qdrws_pkg, qdrws_if.sv and quick_disk_ready_window_sequencer_core_assert.svh.
//
// Usage:
//   i_in carries one word per event: a tick, an index pulse, a resume from a position or a
//   cancel, together with the drive status bits. o_out returns exactly one word per input
//   word: read data enable, ready, a stop-write pulse and the current phase.
//   The four timing registers sit on an APB-style port at byte addresses 0, 4, 8 and 12;
//   writes complete in the access cycle (pready is tied high) and reads return the value.
// Data path:
//   A word accepted into the input register is processed by a single pass through the phase
//   and countdown logic and written to the result register once that register is empty or
//   its word is being taken. One word is accepted per cycle while the result side keeps
//   taking words; a low o_out.ready holds the flow as described under Stalls.
// Reset:
//   i_rst_n is synchronous. It empties both registers, idles the sequencer (phase idle,
//   timer stopped, ready and read data released) and restores the register defaults.
// Stalls:
//   While o_out.ready is low the result word holds; one more word may still be taken
//   into the input register, after which i_in.ready falls until the result is taken.
`timescale 1ns / 1ps
`include "quick_disk_ready_window_sequencer_core_assert.svh"

module quick_disk_ready_window_sequencer_core
    import qdrws_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    qdrws_in_if.sink              i_in,
    qdrws_out_if.source           o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [DATA_WIDTH-1:0] pwdata,
    output logic [DATA_WIDTH-1:0] prdata,
    output logic                  pready
);

    // Configuration registers and the phase lengths derived from them
    logic [CFG_WIDTH-1:0]  r_window_start, n_window_start;
    logic [CFG_WIDTH-1:0]  r_window_end,   n_window_end;
    logic [CFG_WIDTH-1:0]  r_read_lead,    n_read_lead;
    logic [CFG_WIDTH-1:0]  r_read_trail,   n_read_trail;
    logic [TIME_WIDTH-1:0] r_len_lead,     n_len_lead;
    logic [TIME_WIDTH-1:0] r_len_ready,    n_len_ready;
    logic [SUM_WIDTH-1:0]  r_end_read,     n_end_read;
    logic [SUM_WIDTH-1:0]  r_end_ready,    n_end_ready;
    logic [SUM_WIDTH-1:0]  r_end_trail,    n_end_trail;
    logic                  cfg_write;
    t_reg                  cfg_sel;

    // Input register
    logic                  r_in_valid;
    t_op                   r_op;
    logic                  r_motor;
    logic                  r_rd_act;
    logic                  r_wr_act;
    logic                  r_paused;
    logic [CFG_WIDTH-1:0]  r_pos;

    // Sequencer state
    t_phase                r_phase,   n_phase;
    logic [TIME_WIDTH-1:0] r_count,   n_count;
    logic                  r_running, n_running;
    logic                  r_rden,    n_rden;
    logic                  r_rdy,     n_rdy;
    logic                  n_stop;

    // Result register
    logic                  r_out_valid;
    logic                  r_out_rden;
    logic                  r_out_rdy;
    logic                  r_out_stop;
    t_phase                r_out_phase;

    logic                  advance;
    logic [TIME_WIDTH-1:0] count_dec;
    logic [SUM_WIDTH-1:0]  pos_ext;
    logic [SUM_WIDTH-1:0]  end_lead;

    // ---------------------------------------------------------------- configuration
    assign cfg_write = psel && penable && pwrite;
    assign cfg_sel   = t_reg'(paddr[ADDR_WIDTH-1:2]);
    assign pready    = 1'b1;

    always_comb begin
        n_window_start = r_window_start;
        n_window_end   = r_window_end;
        n_read_lead    = r_read_lead;
        n_read_trail   = r_read_trail;
        if (!i_rst_n) begin
            n_window_start = RST_WINDOW_START;
            n_window_end   = RST_WINDOW_END;
            n_read_lead    = RST_READ_LEAD;
            n_read_trail   = RST_READ_TRAIL;
        end else if (cfg_write) begin
            unique case (cfg_sel)
                REG_WINDOW_START: n_window_start = pwdata[CFG_WIDTH-1:0];
                REG_WINDOW_END:   n_window_end   = pwdata[CFG_WIDTH-1:0];
                REG_READ_LEAD:    n_read_lead    = pwdata[CFG_WIDTH-1:0];
                REG_READ_TRAIL:   n_read_trail   = pwdata[CFG_WIDTH-1:0];
                default:          ;
            endcase
        end
    end

    // Phase boundaries are kept as running sums so that a resume needs only compares.
    always_comb begin
        n_len_lead  = sat_sub(n_window_start, n_read_lead);
        n_len_ready = sat_sub(n_window_end, n_window_start);
        n_end_read  = SUM_WIDTH'(n_len_lead) + SUM_WIDTH'(n_read_lead);
        n_end_ready = n_end_read + SUM_WIDTH'(n_len_ready);
        n_end_trail = n_end_ready + SUM_WIDTH'(n_read_trail);
    end

    always_ff @(posedge i_clk) begin
        r_window_start <= n_window_start;
        r_window_end   <= n_window_end;
        r_read_lead    <= n_read_lead;
        r_read_trail   <= n_read_trail;
        r_len_lead     <= n_len_lead;
        r_len_ready    <= n_len_ready;
        r_end_read     <= n_end_read;
        r_end_ready    <= n_end_ready;
        r_end_trail    <= n_end_trail;
    end

    always_comb begin
        unique case (cfg_sel)
            REG_WINDOW_START: prdata = DATA_WIDTH'(r_window_start);
            REG_WINDOW_END:   prdata = DATA_WIDTH'(r_window_end);
            REG_READ_LEAD:    prdata = DATA_WIDTH'(r_read_lead);
            REG_READ_TRAIL:   prdata = DATA_WIDTH'(r_read_trail);
            default:          prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- handshake
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_op     <= t_op'(i_in.operation);
            r_motor  <= i_in.motor_ready;
            r_rd_act <= i_in.read_active;
            r_wr_act <= i_in.write_active;
            r_paused <= i_in.paused;
            r_pos    <= i_in.resume_position;
        end
    end

    // ---------------------------------------------------------------- next state
    assign count_dec = (r_count != '0) ? (r_count - 1'b1) : '0;
    assign pos_ext   = SUM_WIDTH'(r_pos);
    assign end_lead  = SUM_WIDTH'(r_len_lead);

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_running = r_running;
        n_rden    = r_rden;
        n_rdy     = r_rdy;
        unique case (r_op)
            OP_TICK: begin
                if (r_running) begin
                    n_count = count_dec;
                    if (count_dec == '0) begin
                        // Expiry; while paused the timer just stops where it is.
                        n_running = 1'b0;
                        if (!r_paused) begin
                            unique case (r_phase)
                                PH_LEAD: begin
                                    if (r_rd_act) begin
                                        n_rden = 1'b1;
                                    end
                                    n_count   = r_read_lead;
                                    n_running = 1'b1;
                                    n_phase   = PH_READ;
                                end
                                PH_READ: begin
                                    if (r_motor) begin
                                        n_rdy = 1'b1;
                                    end
                                    n_count   = r_len_ready;
                                    n_running = 1'b1;
                                    n_phase   = PH_READY;
                                end
                                PH_READY: begin
                                    n_rdy     = 1'b0;
                                    n_count   = r_read_trail;
                                    n_running = 1'b1;
                                    n_phase   = PH_TRAIL;
                                end
                                PH_TRAIL: begin
                                    n_rden  = 1'b0;
                                    n_phase = PH_DONE;
                                end
                                default: ;
                            endcase
                        end
                    end
                end
            end
            OP_INDEX: begin
                if (r_motor && r_rd_act) begin
                    n_phase   = PH_LEAD;
                    n_count   = r_len_lead;
                    n_running = 1'b1;
                end else begin
                    n_rden    = 1'b0;
                    n_phase   = PH_IDLE;
                    n_count   = '0;
                    n_running = 1'b0;
                end
            end
            OP_RESUME: begin
                if (r_rdy) begin
                    n_rden = 1'b1;
                end
                n_running = 1'b1;
                if (pos_ext < end_lead) begin
                    n_phase = PH_LEAD;
                    n_count = TIME_WIDTH'(end_lead - pos_ext);
                end else if (pos_ext < r_end_read) begin
                    n_phase = PH_READ;
                    n_count = TIME_WIDTH'(r_end_read - pos_ext);
                end else if (pos_ext < r_end_ready) begin
                    n_phase = PH_READY;
                    n_count = TIME_WIDTH'(r_end_ready - pos_ext);
                end else if (pos_ext < r_end_trail) begin
                    n_phase = PH_TRAIL;
                    n_count = TIME_WIDTH'(r_end_trail - pos_ext);
                end else begin
                    n_phase   = PH_DONE;
                    n_count   = '0;
                    n_running = 1'b0;
                end
            end
            OP_CANCEL: begin
                n_phase   = PH_IDLE;
                n_count   = '0;
                n_running = 1'b0;
                n_rden    = 1'b0;
                n_rdy     = 1'b0;
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- outputs
    always_comb begin
        n_stop = (r_op == OP_INDEX) && !(r_motor && r_rd_act) && r_wr_act;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_count   <= '0;
            r_running <= 1'b0;
            r_rden    <= 1'b0;
            r_rdy     <= 1'b0;
        end else if (advance) begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_running <= n_running;
            r_rden    <= n_rden;
            r_rdy     <= n_rdy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_rden  <= n_rden;
            r_out_rdy   <= n_rdy;
            r_out_stop  <= n_stop;
            r_out_phase <= n_phase;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.read_data_enable = r_out_rden;
    assign o_out.ready_asserted   = r_out_rdy;
    assign o_out.stop_write       = r_out_stop;
    assign o_out.phase            = r_out_phase;

    // ---------------------------------------------------------------- assertions
    `QDRWS_ASSERT_IMP(a_stop_only_when_idle, o_out.valid && o_out.stop_write,
                      o_out.phase == PH_IDLE)
    `QDRWS_ASSERT_IMP(a_timer_in_active_phase, r_running,
                      r_phase == PH_LEAD || r_phase == PH_READ || r_phase == PH_READY ||
                      r_phase == PH_TRAIL)
    `QDRWS_ASSERT_IMP(a_full_blocks_input, r_in_valid && r_out_valid && !o_out.ready,
                      !i_in.ready)
    `QDRWS_ASSERT_NXT(a_word_reaches_output, advance, r_out_valid)

endmodule
